// ===== rtl/core/tlca_pkg.sv =====
// ----------------------------------------------------------------------------
// tlca_pkg
// Shared types and constants for the lowest common ancestor block.
// ----------------------------------------------------------------------------
package tlca_pkg;

  localparam int MaxNodes = 1024;
  localparam int NodeW    = $clog2(MaxNodes);
  // wide enough to hold the node count itself
  localparam int CntW     = NodeW + 1;

  typedef logic [NodeW-1:0] node_t;
  typedef logic [CntW-1:0]  cnt_t;

  localparam logic ReqLink  = 1'b0;
  localparam logic ReqQuery = 1'b1;

  // one table entry: link valid flag and parent index
  typedef struct packed {
    logic  valid;
    node_t parent;
  } entry_t;

  // lane 0 follows the first node, lane 1 the second
  typedef struct packed {
    logic             we;
    node_t            waddr;
    entry_t           wdata;
    node_t [1:0]      raddr;
  } ram_req_t;

  typedef struct packed {
    entry_t [1:0] rd;
  } ram_rsp_t;

  typedef struct packed {
    logic  valid;
    node_t ancestor;
    logic  status;
  } fin_t;

endpackage

// ===== rtl/core/tlca_if.sv =====
// ----------------------------------------------------------------------------
// tlca_if
// Request and result channels of the lowest common ancestor block.
// ----------------------------------------------------------------------------
interface tlca_req_if;
  import tlca_pkg::*;

  logic  valid;
  logic  ready;
  logic  req_type;
  node_t node_a;
  node_t node_b;

  modport source (output valid, output req_type, output node_a, output node_b,
                  input ready);
  modport sink   (input valid, input req_type, input node_a, input node_b,
                  output ready);
endinterface

interface tlca_res_if;
  import tlca_pkg::*;

  logic  valid;
  logic  ready;
  node_t ancestor;
  logic  status;

  modport source (output valid, output ancestor, output status, input ready);
  modport sink   (input valid, input ancestor, input status, output ready);
endinterface

// ===== rtl/core/tree_lowest_common_ancestor_top.sv =====
// ----------------------------------------------------------------------------
// tree_lowest_common_ancestor_top
// Lowest common ancestor of two nodes of a rooted tree, root at node 0.
// ----------------------------------------------------------------------------
// After reset the whole parent table is swept clear, during which no request
// is taken (node_count writes still land). A link request writes the parent
// of one node. A query is accepted, then walks both nodes to the root in
// parallel, one parent table read per lane per cycle on a two-read-port RAM,
// to find their depths; then the climb restarts both lanes from the queried
// nodes, moving the deeper lane alone until the depths are equal and then
// both together until they meet at the ancestor, and the answer is handed to
// the output register. A broken walk ends as soon as it is seen, with status
// 1. A finished result waits in the output register while link requests keep
// flowing.
// ----------------------------------------------------------------------------
module tree_lowest_common_ancestor_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  tlca_pkg::cnt_t   cfg_wdata_i,
  tlca_req_if.sink         req_i,
  tlca_res_if.source       res_o
);
  import tlca_pkg::*;

  cnt_t     node_count_q;
  ram_req_t ram_req;
  ram_rsp_t ram_rsp;
  fin_t     fin;
  logic     out_free;
  logic     out_valid_q;
  node_t    out_anc_q;
  logic     out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= cnt_t'(1);
    end else if (cfg_we_i) begin
      node_count_q <= cfg_wdata_i;
    end
  end

  tlca_parent_ram u_ram (
    .clk_i (clk_i),
    .req_i (ram_req),
    .rsp_o (ram_rsp)
  );

  tlca_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .node_count_i (node_count_q),
    .req_i        (req_i),
    .ram_req_o    (ram_req),
    .ram_rsp_i    (ram_rsp),
    .fin_o        (fin),
    .out_free_i   (out_free)
  );

  assign out_free = !out_valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin.valid && out_free) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin.valid && out_free) begin
      out_anc_q    <= fin.ancestor;
      out_status_q <= fin.status;
    end
  end

  assign res_o.valid    = out_valid_q;
  assign res_o.ancestor = out_anc_q;
  assign res_o.status   = out_status_q;

endmodule

// ===== rtl/core/tlca_parent_ram.sv =====
// ----------------------------------------------------------------------------
// tlca_parent_ram
// Parent table: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module tlca_parent_ram (
  input  logic               clk_i,
  input  tlca_pkg::ram_req_t req_i,
  output tlca_pkg::ram_rsp_t rsp_o
);
  import tlca_pkg::*;

  entry_t mem [MaxNodes];
  entry_t rd_a_q;
  entry_t rd_b_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_a_q <= mem[req_i.raddr[0]];
    rd_b_q <= mem[req_i.raddr[1]];
  end

  assign rsp_o.rd[0] = rd_a_q;
  assign rsp_o.rd[1] = rd_b_q;

endmodule

// ===== rtl/core/tlca_ctrl.sv =====
// ----------------------------------------------------------------------------
// tlca_ctrl
// Sequencer: table clearing, link writes, depth walks and the climb.
// ----------------------------------------------------------------------------
module tlca_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tlca_pkg::cnt_t     node_count_i,
  tlca_req_if.sink           req_i,
  output tlca_pkg::ram_req_t ram_req_o,
  input  tlca_pkg::ram_rsp_t ram_rsp_i,
  output tlca_pkg::fin_t     fin_o,
  input  logic               out_free_i
);
  import tlca_pkg::*;

  localparam logic [2:0] StClear  = 3'd0;
  localparam logic [2:0] StIdle   = 3'd1;
  localparam logic [2:0] StWalk   = 3'd2;
  localparam logic [2:0] StClimb  = 3'd3;
  localparam logic [2:0] StFinish = 3'd4;

  localparam cnt_t  MaxCount = cnt_t'(MaxNodes);
  localparam node_t LastNode = node_t'(MaxNodes - 1);

  logic [2:0]  state_q, state_d;
  node_t       clr_q, clr_d;
  node_t [1:0] x_q, x_d;
  node_t [1:0] orig_q, orig_d;
  cnt_t  [1:0] dep_q, dep_d;
  logic  [1:0] done_q, done_d;
  logic        fail_q, fail_d;
  node_t       ans_q, ans_d;

  cnt_t        live;
  logic  [1:0] lane_done;
  logic  [1:0] lane_fail;
  logic  [1:0] lane_move;

  // count zero acts as one, anything above the table size is clamped
  always_comb begin
    live = node_count_i;
    if (node_count_i == '0) begin
      live = cnt_t'(1);
    end else if (node_count_i > MaxCount) begin
      live = MaxCount;
    end
  end

  assign lane_move[0] = dep_q[0] >= dep_q[1];
  assign lane_move[1] = dep_q[1] >= dep_q[0];

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    x_d       = x_q;
    orig_d    = orig_q;
    dep_d     = dep_q;
    done_d    = done_q;
    fail_d    = fail_q;
    ans_d     = ans_q;
    lane_done = done_q;
    lane_fail = '0;

    ram_req_o.we    = 1'b0;
    ram_req_o.waddr = req_i.node_a;
    ram_req_o.wdata = '{valid: 1'b1, parent: req_i.node_b};
    ram_req_o.raddr = x_q;

    req_i.ready    = 1'b0;
    fin_o.valid    = 1'b0;
    fin_o.ancestor = ans_q;
    fin_o.status   = fail_q;

    unique case (state_q)
      StClear: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = clr_q;
        ram_req_o.wdata = '0;
        clr_d           = clr_q + 1'b1;
        if (clr_q == LastNode) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          // every child index fits the table, so a link is always stored
          if (req_i.req_type == ReqLink) begin
            ram_req_o.we = 1'b1;
          end else begin
            orig_d          = {req_i.node_b, req_i.node_a};
            x_d             = {req_i.node_b, req_i.node_a};
            ram_req_o.raddr = {req_i.node_b, req_i.node_a};
            dep_d           = '0;
            done_d          = '0;
            state_d         = StWalk;
          end
        end
      end
      StWalk: begin
        // read data holds the entry of the lane's current node
        for (int i = 0; i < 2; i++) begin
          if (!done_q[i]) begin
            if (x_q[i] == '0) begin
              lane_done[i] = 1'b1;
            end else if (cnt_t'(x_q[i]) >= live || !ram_rsp_i.rd[i].valid ||
                         dep_q[i] >= live) begin
              lane_fail[i] = 1'b1;
            end else begin
              x_d[i]             = ram_rsp_i.rd[i].parent;
              dep_d[i]           = dep_q[i] + 1'b1;
              ram_req_o.raddr[i] = ram_rsp_i.rd[i].parent;
            end
          end
        end
        done_d = lane_done;
        if (|lane_fail) begin
          fail_d  = 1'b1;
          ans_d   = '0;
          state_d = StFinish;
        end else if (&lane_done) begin
          // restart both lanes from the queried nodes
          x_d             = orig_q;
          ram_req_o.raddr = orig_q;
          state_d         = StClimb;
        end
      end
      StClimb: begin
        if (x_q[0] == x_q[1]) begin
          ans_d   = x_q[0];
          fail_d  = 1'b0;
          state_d = StFinish;
        end else begin
          // deeper lane moves alone, equal depths move together
          for (int i = 0; i < 2; i++) begin
            if (lane_move[i]) begin
              x_d[i]             = ram_rsp_i.rd[i].parent;
              dep_d[i]           = dep_q[i] - 1'b1;
              ram_req_o.raddr[i] = ram_rsp_i.rd[i].parent;
            end
          end
        end
      end
      StFinish: begin
        fin_o.valid = 1'b1;
        if (out_free_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q   <= '0;
      done_q  <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    orig_q <= orig_d;
    dep_q  <= dep_d;
    fail_q <= fail_d;
    ans_q  <= ans_d;
  end

endmodule
